### rtl/core/msort_pkg.sv
// Shared constants, types and cell control for the merge sorter unit.
`timescale 1ns / 1ps

package msort_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_BITS-1:0] t_key;
    typedef logic [CNT_BITS-1:0] t_count;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic drain;
    } t_cell_ctl;

endpackage

### rtl/core/msort_cell.sv
// One sorting cell: holds one key, inserts in order and drains toward the head.
`timescale 1ns / 1ps

module msort_cell (
    input  logic               i_clk,
    input  msort_pkg::t_cell_ctl i_ctl,
    input  msort_pkg::t_key    i_key,
    input  logic               i_occupied,
    input  msort_pkg::t_key    i_prev_key,
    input  logic               i_prev_gt,
    input  msort_pkg::t_key    i_next_key,
    output msort_pkg::t_key    o_key,
    output logic               o_gt
);
    import msort_pkg::*;

    t_key r_key;
    t_key n_key;

    // An empty cell behaves as if it held a key above every other key.
    // Equal keys do not move, so a new key lands after its equals.
    assign o_gt = !i_occupied || (r_key > i_key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.load && o_gt) begin
            n_key = i_prev_gt ? i_prev_key : i_key;
        end else if (i_ctl.drain) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

### rtl/core/merge_sorter_unit.sv
// Top level of the merge sorter unit: control and a chain of sorting cells.
// A set's keys are taken one a cycle; the first result is offered in the cycle after
// the last key is taken, and results then drain one a cycle while the receiver is ready.
// Sets do not overlap: the single shared key chain either takes keys in or shifts results
// out, so the next set is taken only after the last result of the previous set.
// Reset: i_rst_n is synchronous and active low; it empties the store and clears the
// overflow flag. Stored keys themselves are not reset.
`timescale 1ns / 1ps

module merge_sorter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [msort_pkg::KEY_BITS-1:0] i_s_axis_tdata,  // key
    input  logic                          i_s_axis_tlast,  // final_key
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [msort_pkg::KEY_BITS-1:0] o_m_axis_tdata,  // sorted_key
    output logic                          o_m_axis_tlast,  // final_result
    output logic                          o_m_axis_tuser   // overflowed
);
    import msort_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_count    r_count;
    t_count    n_count;
    logic      r_overflow;
    logic      n_overflow;
    t_cell_ctl w_ctl;
    logic      w_in_req;
    logic      w_out_req;

    t_key      w_key [CAPACITY];
    logic      w_gt  [CAPACITY];

    assign w_in_req  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_req = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_overflow      = r_overflow;
        w_ctl.load      = 1'b0;
        w_ctl.drain     = 1'b0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                if (w_in_req) begin
                    if (r_count < t_count'(CAPACITY)) begin
                        w_ctl.load = 1'b1;
                        n_count    = r_count + t_count'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_m_axis_tvalid = 1'b1;
                if (w_out_req) begin
                    w_ctl.drain = 1'b1;
                    n_count     = r_count - t_count'(1);
                    if (r_count == t_count'(1)) begin
                        n_state    = ST_LOAD;
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_key w_prev_key;
            logic w_prev_gt;
            t_key w_next_key;

            if (g == 0) begin : g_head
                assign w_prev_key = t_key'(i_s_axis_tdata);
                assign w_prev_gt  = 1'b0;
            end else begin : g_body
                assign w_prev_key = w_key[g-1];
                assign w_prev_gt  = w_gt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_next_key = w_key[g];
            end else begin : g_inner
                assign w_next_key = w_key[g+1];
            end

            msort_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_key      (t_key'(i_s_axis_tdata)),
                .i_occupied (t_count'(g) < r_count),
                .i_prev_key (w_prev_key),
                .i_prev_gt  (w_prev_gt),
                .i_next_key (w_next_key),
                .o_key      (w_key[g]),
                .o_gt       (w_gt[g])
            );
        end
    endgenerate

    assign o_m_axis_tdata = w_key[0];
    assign o_m_axis_tlast = (r_count == t_count'(1));
    assign o_m_axis_tuser = r_overflow;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("Key count exceeds capacity.");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_count != '0))
        else $error("Result offered from an empty store.");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_axis_tvalid && o_s_axis_tready))
        else $error("Input and output sides active together.");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_req && o_m_axis_tlast) |=> (o_s_axis_tready && r_count == '0 && !r_overflow))
        else $error("Block not cleared after the last result of a set.");
`endif

endmodule

### bench/tb.sv
// Self-checking testbench for the merge sorter unit: directed sets, random sets and overflow.
`timescale 1ns / 1ps

module tb;
    import msort_pkg::*;

    localparam t_key KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam t_key KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam int N_DIRECTED = 21;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int PHASE_RAND_ITEMS = 4;

    typedef struct packed {
        t_key key;
        logic last;
        logic ovf;
    } t_sorted_item;

    typedef struct packed {
        t_key key;
        logic last;
        logic typed;
        t_key want_key;
        logic want_last;
        logic want_ovf;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [KEY_BITS-1:0] i_s_axis_tdata;
    logic i_s_axis_tlast;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [KEY_BITS-1:0] o_m_axis_tdata;
    logic o_m_axis_tlast;
    logic o_m_axis_tuser;

    t_key held_keys [CAPACITY];
    int held_count;
    logic held_ovf;
    t_sorted_item sorted_batch [$];
    t_sorted_item pending_sorted [$];

    int send_idle_pct;
    int recv_idle_pct;
    int idle_phase;
    bit long_hold_done;
    int fail_count;
    int mismatch_count;
    int results_seen;
    int sets_sent;
    int keys_sent;
    int overflow_sets;
    int rand_items;

    merge_sorter_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stores one key and, on the last key of a set, leaves the stably sorted set in sorted_batch.
    task automatic absorb_key(input t_key key, input logic last);
        t_key ordered [CAPACITY];
        int pos;
        t_sorted_item item;
        if (held_count < CAPACITY) begin
            held_keys[held_count] = key;
            held_count++;
        end else begin
            held_ovf = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < held_count; i++) begin
                pos = i;
                while (pos > 0 && ordered[pos-1] > held_keys[i]) begin
                    ordered[pos] = ordered[pos-1];
                    pos--;
                end
                ordered[pos] = held_keys[i];
            end
            for (int i = 0; i < held_count; i++) begin
                item.key = ordered[i];
                item.last = (i == held_count - 1);
                item.ovf = held_ovf;
                sorted_batch.push_back(item);
            end
            if (held_ovf) begin
                overflow_sets++;
            end
            sets_sent++;
            held_count = 0;
            held_ovf = 1'b0;
        end
    endtask

    task automatic send_key(input t_key key, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = key;
        i_s_axis_tlast = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        keys_sent++;
        absorb_key(key, last);
    endtask

    function automatic t_key random_key();
        t_key k;
        case ($urandom_range(3))
            0: begin
                k = $urandom_range(8);
                k = k - 4;
            end
            1: begin
                case ($urandom_range(3))
                    0: k = KEY_MIN;
                    1: k = KEY_MAX;
                    2: k = '0;
                    default: k = '1;
                endcase
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic send_random_set(input int n);
        for (int i = 0; i < n; i++) begin
            send_key(random_key(), i == n - 1);
            pending_sorted = {pending_sorted, sorted_batch};
            sorted_batch.delete();
        end
    endtask

    initial begin
        i_m_axis_tready = 1'b0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_phase == 2 && !long_hold_done && o_m_axis_tvalid) begin
                // The receiver stalls long enough for the next set to back up the input.
                i_m_axis_tready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                i_m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sorted_item want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_sorted.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result: key %0d last %b overflow %b",
                             $signed(o_m_axis_tdata), o_m_axis_tlast, o_m_axis_tuser);
                end
            end else begin
                want = pending_sorted.pop_front();
                if (o_m_axis_tdata !== want.key || o_m_axis_tlast !== want.last
                        || o_m_axis_tuser !== want.ovf) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"Mismatch: expected key %0d last %b overflow %b, ",
                                  "got key %0d last %b overflow %b"},
                                 want.key, want.last, want.ovf, $signed(o_m_axis_tdata),
                                 o_m_axis_tlast, o_m_axis_tuser);
                    end
                end
            end
        end
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_stim_row rows [N_DIRECTED];
        t_sorted_item typed_item;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        held_count = 0;
        held_ovf = 1'b0;
        fail_count = 0;
        mismatch_count = 0;
        results_seen = 0;
        sets_sent = 0;
        keys_sent = 0;
        overflow_sets = 0;
        rand_items = 0;
        idle_phase = 0;
        send_idle_pct = 6;
        recv_idle_pct = 83;

        rows[0]  = '{KEY_MIN, 1'b1, 1'b1, KEY_MIN, 1'b1, 1'b0};
        rows[1]  = '{KEY_MAX, 1'b1, 1'b1, KEY_MAX, 1'b1, 1'b0};
        rows[2]  = '{t_key'(0), 1'b1, 1'b1, t_key'(0), 1'b1, 1'b0};
        rows[3]  = '{t_key'(-1), 1'b1, 1'b1, t_key'(-1), 1'b1, 1'b0};
        rows[4]  = '{t_key'(5), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[5]  = '{t_key'(-3), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[6]  = '{t_key'(5), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[7]  = '{t_key'(-3), 1'b1, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[8]  = '{KEY_MAX, 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[9]  = '{KEY_MIN, 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[10] = '{t_key'(0), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[11] = '{t_key'(-1), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[12] = '{t_key'(1), 1'b1, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[13] = '{t_key'(1), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[14] = '{t_key'(1), 1'b1, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[15] = '{t_key'(3), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[16] = '{t_key'(2), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[17] = '{t_key'(1), 1'b1, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[18] = '{t_key'(32'h5555_5555), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[19] = '{t_key'(32'hAAAA_AAAA), 1'b0, 1'b0, t_key'(0), 1'b0, 1'b0};
        rows[20] = '{t_key'(32'h7FFF_0000), 1'b1, 1'b0, t_key'(0), 1'b0, 1'b0};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_key(rows[r].key, rows[r].last);
            if (rows[r].typed) begin
                typed_item.key = rows[r].want_key;
                typed_item.last = rows[r].want_last;
                typed_item.ovf = rows[r].want_ovf;
                pending_sorted.push_back(typed_item);
            end else begin
                pending_sorted = {pending_sorted, sorted_batch};
            end
            sorted_batch.delete();
        end

        for (int p = 0; p < 3; p++) begin
            idle_phase = p;
            rand_items = 0;
            send_idle_pct = (p == 0) ? 6 : (p == 1) ? 83 : 0;
            recv_idle_pct = (p == 0) ? 83 : (p == 1) ? 6 : 0;
            // A set that exactly fills the store, then one whose last two keys are dropped.
            if (p == 1) begin
                send_random_set(CAPACITY);
            end else if (p == 2) begin
                send_random_set(CAPACITY + 2);
            end
            while (rand_items < PHASE_RAND_ITEMS) begin
                automatic int n = ($urandom_range(4) == 0) ? $urandom_range(9, 20)
                                                           : $urandom_range(1, 8);
                send_random_set(n);
                rand_items += n;
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast = 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d keys in %0d sets, %0d of them overflowing the store.",
                 keys_sent, sets_sent, overflow_sets);
        $display("Checked %0d sorted results with %0d mismatches.", results_seen, mismatch_count);
        if (fail_count == 0 && pending_sorted.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
